>>> rtl/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and constants of the LED strip bit symbol encoder: register
// indexes, register reset values, tick timing bundle and field widths.
// ----------------------------------------------------------------------------
package lsbse_pkg;

	localparam int BYTE_W    = 8;
	localparam int TICK_W    = 15;
	localparam int PROD_W    = 2 * BYTE_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = TICK_W;

	// Symbol counter runs over the eight bit symbols plus the latch symbol
	localparam int BITS_PER_BYTE = 8;
	localparam int CNT_W         = 4;

	localparam logic [BYTE_W-1:0] FULL_SCALE = 8'd255;

	// Register reset values
	localparam logic [BYTE_W-1:0] RST_BRIGHTNESS = 8'd255;
	localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 15'd8;
	localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 15'd22;
	localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 15'd16;
	localparam logic [TICK_W-1:0] RST_ONE_LOW    = 15'd14;
	localparam logic [TICK_W-1:0] RST_LATCH      = 15'd800;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_ZERO_LOW   = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_ONE_LOW    = 3'd4,
		REG_LATCH      = 3'd5
	} reg_idx_t;

	// Phase lengths handed to the symbol generator
	typedef struct packed {
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] latch;
	} timing_t;

	// One pulse symbol
	typedef struct packed {
		logic              first_level;
		logic [TICK_W-1:0] first_ticks;
		logic              second_level;
		logic [TICK_W-1:0] second_ticks;
		logic              run_last;
	} symbol_t;

endpackage

>>> rtl/lsbse_sym_gen.sv
// ----------------------------------------------------------------------------
// lsbse_sym_gen
// Holds one scaled byte in a shift register and emits one pulse symbol per
// cycle into an output register: eight bit symbols, MSB first, then a latch
// symbol when the byte ends a frame; sym_ready can stall it. Loads the next
// byte in the cycle its last symbol leaves, so bytes follow without a gap.
// ----------------------------------------------------------------------------
module lsbse_sym_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsbse_pkg::timing_t             timing,
	input  logic                           load_valid,
	output logic                           load_ready,
	input  logic [lsbse_pkg::BYTE_W-1:0]   load_byte,
	input  logic                           load_end,
	output logic                           sym_valid,
	input  logic                           sym_ready,
	output lsbse_pkg::symbol_t             sym
);

	logic                           busy_q;
	logic [lsbse_pkg::BYTE_W-1:0]   shift_q;
	logic [lsbse_pkg::CNT_W-1:0]    cnt_q;
	logic                           end_q;
	logic                           out_valid_q;
	lsbse_pkg::symbol_t             out_q;

	lsbse_pkg::symbol_t             next_sym;
	logic                           advance;
	logic                           finish;
	logic                           load;
	logic                           is_latch;

	// Build the symbol for the current position
	always_comb begin
		is_latch = (cnt_q == lsbse_pkg::CNT_W'(lsbse_pkg::BITS_PER_BYTE));
		if (is_latch) begin
			next_sym.first_level  = 1'b0;
			next_sym.first_ticks  = timing.latch;
			next_sym.second_level = 1'b0;
			next_sym.second_ticks = '0;
			next_sym.run_last     = 1'b1;
		end else begin
			next_sym.first_level  = 1'b1;
			next_sym.first_ticks  = shift_q[lsbse_pkg::BYTE_W-1] ? timing.one_high
				: timing.zero_high;
			next_sym.second_level = 1'b0;
			next_sym.second_ticks = shift_q[lsbse_pkg::BYTE_W-1] ? timing.one_low
				: timing.zero_low;
			next_sym.run_last     = !end_q &&
				(cnt_q == lsbse_pkg::CNT_W'(lsbse_pkg::BITS_PER_BYTE - 1));
		end
	end

	// Advance when the output register is free or drains this cycle
	assign advance    = busy_q && (!out_valid_q || sym_ready);
	assign finish     = advance && next_sym.run_last;
	assign load_ready = !busy_q || finish;
	assign load       = load_valid && load_ready;

	// Shift register and symbol counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= load_byte;
			cnt_q   <= '0;
			end_q   <= load_end;
		end else if (advance) begin
			shift_q <= {shift_q[lsbse_pkg::BYTE_W-2:0], 1'b0};
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (sym_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_sym;
		end
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

endmodule

>>> rtl/led_strip_bit_symbol_encoder.sv
// ----------------------------------------------------------------------------
// led_strip_bit_symbol_encoder
// Scales each color byte by the brightness register (byte*brightness/255,
// truncated) and turns it into pulse symbols for an LED strip line.
// ----------------------------------------------------------------------------
// A byte's first symbol passes the product register, then the shift
//   register, then the output register.
// Throughput: one symbol per cycle while out_ready does not stall it, so
//   eight symbols per byte, nine for a byte that ends a frame.
// Reset: registers return to their defaults, all stages empty.
module led_strip_bit_symbol_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsbse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsbse_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lsbse_pkg::BYTE_W-1:0]      color_byte,
	input  logic                              frame_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              first_level,
	output logic [lsbse_pkg::TICK_W-1:0]      first_ticks,
	output logic                              second_level,
	output logic [lsbse_pkg::TICK_W-1:0]      second_ticks,
	output logic                              run_last
);

	logic [lsbse_pkg::BYTE_W-1:0]   brightness_q;
	lsbse_pkg::timing_t             timing_q;

	logic                           valid_s1;
	logic [lsbse_pkg::PROD_W-1:0]   prod_s1;
	logic                           end_s1;

	logic [lsbse_pkg::BYTE_W-1:0]   quot_est;
	logic [lsbse_pkg::PROD_W-1:0]   rem_full;
	logic [lsbse_pkg::BYTE_W-1:0]   scaled;
	logic                           load_ready;
	lsbse_pkg::symbol_t             sym;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q       <= lsbse_pkg::RST_BRIGHTNESS;
			timing_q.zero_high <= lsbse_pkg::RST_ZERO_HIGH;
			timing_q.zero_low  <= lsbse_pkg::RST_ZERO_LOW;
			timing_q.one_high  <= lsbse_pkg::RST_ONE_HIGH;
			timing_q.one_low   <= lsbse_pkg::RST_ONE_LOW;
			timing_q.latch     <= lsbse_pkg::RST_LATCH;
		end else if (cfg_we) begin
			case (cfg_index)
				lsbse_pkg::REG_BRIGHTNESS: begin
					brightness_q <= cfg_wdata[lsbse_pkg::BYTE_W-1:0];
				end
				lsbse_pkg::REG_ZERO_HIGH: timing_q.zero_high <= cfg_wdata;
				lsbse_pkg::REG_ZERO_LOW:  timing_q.zero_low  <= cfg_wdata;
				lsbse_pkg::REG_ONE_HIGH:  timing_q.one_high  <= cfg_wdata;
				lsbse_pkg::REG_ONE_LOW:   timing_q.one_low   <= cfg_wdata;
				lsbse_pkg::REG_LATCH:     timing_q.latch     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage: register the brightness product
	assign in_ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= lsbse_pkg::PROD_W'(color_byte) * lsbse_pkg::PROD_W'(brightness_q);
			end_s1  <= frame_end;
		end
	end

	// Divide by 255: p>>8 is the quotient or one short; fix with one compare
	always_comb begin
		quot_est = prod_s1[lsbse_pkg::PROD_W-1:lsbse_pkg::BYTE_W];
		rem_full = prod_s1 - ({quot_est, {lsbse_pkg::BYTE_W{1'b0}}}
			- lsbse_pkg::PROD_W'(quot_est));
		if (rem_full >= lsbse_pkg::PROD_W'(lsbse_pkg::FULL_SCALE)) begin
			scaled = quot_est + 1'b1;
		end else begin
			scaled = quot_est;
		end
	end

	lsbse_sym_gen u_sym_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.timing     (timing_q),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.load_byte  (scaled),
		.load_end   (end_s1),
		.sym_valid  (out_valid),
		.sym_ready  (out_ready),
		.sym        (sym)
	);

	assign first_level  = sym.first_level;
	assign first_ticks  = sym.first_ticks;
	assign second_level = sym.second_level;
	assign second_ticks = sym.second_ticks;
	assign run_last     = sym.run_last;

	// A latch symbol always closes its byte and has an empty second phase
	a_latch_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_level |-> run_last && second_ticks == '0)
		else $error("latch symbol malformed");

	// A held product stays put until the generator takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_ready |=> valid_s1 && $stable(prod_s1) && $stable(end_s1))
		else $error("input stage lost or changed a byte");

	// Bit symbols start high and end low
	a_bit_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_level |-> !second_level)
		else $error("bit symbol levels wrong");

endmodule
